@@ rtl/core/assert_macros.svh @@
// Assertion macros for the frame statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, held off while reset is asserted.
`define FPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs during reset.
`define FPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPS_ASSERT(lbl, prop, msg)
`define FPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/core/fps_pkg.sv @@
// Types and constants for the frame pixel statistics core.
package fps_pkg;

    localparam int unsigned SIDE_W   = 13;
    localparam int unsigned AREA_W   = 2 * SIDE_W;
    localparam int unsigned CNT_W    = 25;
    localparam int unsigned TOT_W    = 32;
    localparam int unsigned MEAN_W   = 16;
    localparam int unsigned HASH_W   = 64;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    // FNV prime is 2^40 + 435: a shift plus a narrow multiply
    localparam int unsigned       FNV_SHIFT  = 40;
    localparam logic [8:0]        FNV_MUL_LO = 9'd435;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic              last_pixel;
        logic              frame_rendered;
    } pixel_t;

    typedef struct packed {
        logic              frame_valid;
        logic [HASH_W-1:0] pixel_hash;
        logic [CNT_W-1:0]  nonblack_count;
        logic [MEAN_W-1:0] mean_red;
        logic [MEAN_W-1:0] mean_green;
        logic [MEAN_W-1:0] mean_blue;
    } result_t;

    typedef struct packed {
        logic              step;
        logic              clear;
        logic [BYTE_W-1:0] data;
    } hash_ctrl_t;

    typedef struct packed {
        logic                    start;
        logic [TOT_W-BYTE_W-1:0] num_hi;
        logic [BYTE_W-1:0]       num_lo;
        logic [AREA_W-1:0]       den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [MEAN_W-1:0] quot;
    } div_rsp_t;

endpackage

@@ rtl/core/fps_hash_unit.sv @@
// FNV-1a 64-bit hash register with a one-byte-per-cycle update step.
module fps_hash_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fps_pkg::hash_ctrl_t        ctrl,
    output logic [fps_pkg::HASH_W-1:0] hash
);
    import fps_pkg::*;

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] mix;

    // xor in the byte, then multiply by the prime as shift plus small product
    assign mix = hash_reg ^ {{(HASH_W-BYTE_W){1'b0}}, ctrl.data};

    always_comb
    begin
        hash_next = hash_reg;
        if (ctrl.clear)
        begin
            hash_next = FNV_BASIS;
        end
        else if (ctrl.step)
        begin
            hash_next = (mix << FNV_SHIFT) + (mix * {{(HASH_W-9){1'b0}}, FNV_MUL_LO});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign hash = hash_reg;

endmodule

@@ rtl/core/fps_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the Q8.8 channel means.
module fps_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  fps_pkg::div_req_t req,
    output fps_pkg::div_rsp_t rsp
);
    import fps_pkg::*;

    localparam int unsigned STEP_W = $clog2(MEAN_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MEAN_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [AREA_W-1:0]   rem_reg, rem_next;
    logic [AREA_W-1:0]   den_reg, den_next;
    logic [MEAN_W-1:0]   sh_reg, sh_next;
    logic [MEAN_W-1:0]   quot_reg, quot_next;
    logic [AREA_W:0]     trial;
    logic [AREA_W:0]     diff;
    logic                take;

    assign trial = {rem_reg, sh_reg[MEAN_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            // upper dividend bits are already below the divisor
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = {{(AREA_W-(TOT_W-BYTE_W)){1'b0}}, req.num_hi};
            sh_next   = {req.num_lo, {(MEAN_W-BYTE_W){1'b0}}};
            den_next  = req.den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? diff[AREA_W-1:0] : trial[AREA_W-1:0];
            quot_next = {quot_reg[MEAN_W-2:0], take};
            sh_next   = {sh_reg[MEAN_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        sh_reg   <= sh_next;
        quot_reg <= quot_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ rtl/core/frame_pixel_statistics_core.sv @@
// Frame pixel statistics: FNV-1a 64 hash, non-black count and RGB means per frame.
// A frame arrives as RGBA pixel requests, the final one marked by last_pixel.
// Each pixel is paced by the single hash unit, which folds one byte
// (R, G, B, then A) into the FNV-1a state per cycle; the next pixel request is
// taken in the cycle of the alpha step. Channel sums, the pixel count and the
// non-black count update at request acceptance. After the alpha step of the
// last pixel a valid frame passes through S_AREA to form width times height,
// S_CHECK to check frame validity, S_DIV for each of red, green and blue in
// the shared bit-serial divider (a start, 16 quotient bits and a done), and
// S_LOAD to load the result register; an invalid frame skips the divider.
// Pixel requests are held off during that time. The result register decouples
// the output: the next frame may start while a result waits, and only the next
// result load waits for it to drain. A frame is valid only when it was rendered,
// both sides are nonzero and at most MAX_SIDE, the pixel count has not saturated
// and equals the area; an invalid frame reports all statistics as zero. Frame
// state clears after each result. frame_width and frame_height are written
// through cfg_we, cfg_addr (0 width, 1 height) and cfg_data; the user must
// write them only while the core is idle, as the core does not enforce it.
`include "assert_macros.svh"
module frame_pixel_statistics_core #(
    parameter int unsigned MAX_SIDE = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  fps_pkg::pixel_t               pix,
    output logic                          res_valid,
    input  logic                          res_stall,
    output fps_pkg::result_t              res,
    input  logic                          cfg_we,
    input  logic [fps_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [fps_pkg::SIDE_W-1:0]    cfg_data
);
    import fps_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_AREA  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_LOAD  = 3'd5;

    localparam logic [1:0] BYTE_R = 2'd0;
    localparam logic [1:0] BYTE_G = 2'd1;
    localparam logic [1:0] BYTE_B = 2'd2;
    localparam logic [1:0] BYTE_A = 2'd3;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // sequencer
    logic [2:0]        state_reg, state_next;
    logic [1:0]        byte_reg, byte_next;
    logic [1:0]        chan_reg, chan_next;
    logic              started_reg, started_next;
    pixel_t            pix_reg, pix_next;

    // frame accumulators
    logic [TOT_W-1:0]  red_reg, red_next;
    logic [TOT_W-1:0]  green_reg, green_next;
    logic [TOT_W-1:0]  blue_reg, blue_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic [CNT_W-1:0]  nonblack_reg, nonblack_next;

    // configuration and frame-end check
    logic [SIDE_W-1:0] width_reg, height_reg;
    logic [AREA_W-1:0] area_reg, area_next;
    logic              fvalid_reg, fvalid_next;
    logic [MEAN_W-1:0] mred_reg, mred_next;
    logic [MEAN_W-1:0] mgreen_reg, mgreen_next;
    logic [MEAN_W-1:0] mblue_reg, mblue_next;

    // result register
    result_t           res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    hash_ctrl_t        hash_ctrl;
    logic [HASH_W-1:0] hash_val;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              pix_take;
    logic              pix_ready;
    logic [TOT_W:0]    red_sum, green_sum, blue_sum;
    logic [CNT_W:0]    seen_sum, nonblack_sum;
    logic              is_nonblack;
    logic [TOT_W-1:0]  div_total;
    logic              res_free;

    fps_hash_unit u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (hash_ctrl),
        .hash  (hash_val)
    );

    fps_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // take a new pixel when idle, or during the alpha step of a pixel that is not last
    assign pix_ready = (state_reg == S_IDLE) ||
                       ((state_reg == S_HASH) && (byte_reg == BYTE_A) && !pix_reg.last_pixel);
    assign pix_stall = !pix_ready;
    assign pix_take  = pix_valid && pix_ready;

    // saturating accumulation of the incoming pixel
    assign red_sum      = {1'b0, red_reg}   + {{(TOT_W+1-BYTE_W){1'b0}}, pix.red};
    assign green_sum    = {1'b0, green_reg} + {{(TOT_W+1-BYTE_W){1'b0}}, pix.green};
    assign blue_sum     = {1'b0, blue_reg}  + {{(TOT_W+1-BYTE_W){1'b0}}, pix.blue};
    assign seen_sum     = {1'b0, seen_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign nonblack_sum = {1'b0, nonblack_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign is_nonblack  = (pix.red != '0) || (pix.green != '0) || (pix.blue != '0);

    assign res_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        case (chan_reg)
            CH_RED:   div_total = red_reg;
            CH_GREEN: div_total = green_reg;
            default:  div_total = blue_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        chan_next      = chan_reg;
        started_next   = started_reg;
        pix_next       = pix_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        seen_next      = seen_reg;
        nonblack_next  = nonblack_reg;
        area_next      = area_reg;
        fvalid_next    = fvalid_reg;
        mred_next      = mred_reg;
        mgreen_next    = mgreen_reg;
        mblue_next     = mblue_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        hash_ctrl.step  = 1'b0;
        hash_ctrl.clear = 1'b0;
        case (byte_reg)
            BYTE_R:  hash_ctrl.data = pix_reg.red;
            BYTE_G:  hash_ctrl.data = pix_reg.green;
            BYTE_B:  hash_ctrl.data = pix_reg.blue;
            default: hash_ctrl.data = pix_reg.alpha;
        endcase

        div_req.start  = 1'b0;
        div_req.num_hi = div_total[TOT_W-1:BYTE_W];
        div_req.num_lo = div_total[BYTE_W-1:0];
        div_req.den    = area_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // accept handled below
            end
            S_HASH:
            begin
                // fold one byte per cycle; after alpha, drop back or finish the frame
                hash_ctrl.step = 1'b1;
                byte_next      = byte_reg + 1'b1;
                if (byte_reg == BYTE_A)
                begin
                    state_next = pix_reg.last_pixel ? S_AREA : S_IDLE;
                end
            end
            S_AREA:
            begin
                area_next  = AREA_W'(width_reg) * AREA_W'(height_reg);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                fvalid_next = pix_reg.frame_rendered &&
                              (width_reg != '0) && (height_reg != '0) &&
                              (32'(width_reg) <= 32'(MAX_SIDE)) &&
                              (32'(height_reg) <= 32'(MAX_SIDE)) &&
                              (seen_reg != CNT_MAX) &&
                              ({1'b0, seen_reg} == area_reg);
                chan_next    = CH_RED;
                started_next = 1'b0;
                state_next   = fvalid_next ? S_DIV : S_LOAD;
            end
            S_DIV:
            begin
                // one channel at a time through the shared divider
                if (!started_reg)
                begin
                    div_req.start = 1'b1;
                    started_next  = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    started_next = 1'b0;
                    case (chan_reg)
                        CH_RED:   mred_next   = div_rsp.quot;
                        CH_GREEN: mgreen_next = div_rsp.quot;
                        default:  mblue_next  = div_rsp.quot;
                    endcase
                    if (chan_reg == CH_BLUE)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        chan_next = chan_reg + 1'b1;
                    end
                end
            end
            S_LOAD:
            begin
                // hold until the result register is free, then load and clear the frame
                if (res_free)
                begin
                    res_valid_next          = 1'b1;
                    res_next.frame_valid    = fvalid_reg;
                    res_next.pixel_hash     = fvalid_reg ? hash_val : '0;
                    res_next.nonblack_count = fvalid_reg ? nonblack_reg : '0;
                    res_next.mean_red       = fvalid_reg ? mred_reg : '0;
                    res_next.mean_green     = fvalid_reg ? mgreen_reg : '0;
                    res_next.mean_blue      = fvalid_reg ? mblue_reg : '0;
                    hash_ctrl.clear         = 1'b1;
                    red_next                = '0;
                    green_next              = '0;
                    blue_next               = '0;
                    seen_next               = '0;
                    nonblack_next           = '0;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pix_take)
        begin
            pix_next      = pix;
            byte_next     = BYTE_R;
            state_next    = S_HASH;
            red_next      = red_sum[TOT_W]   ? TOT_MAX : red_sum[TOT_W-1:0];
            green_next    = green_sum[TOT_W] ? TOT_MAX : green_sum[TOT_W-1:0];
            blue_next     = blue_sum[TOT_W]  ? TOT_MAX : blue_sum[TOT_W-1:0];
            seen_next     = seen_sum[CNT_W]  ? CNT_MAX : seen_sum[CNT_W-1:0];
            if (is_nonblack)
            begin
                nonblack_next = nonblack_sum[CNT_W] ? CNT_MAX : nonblack_sum[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            byte_reg      <= BYTE_R;
            chan_reg      <= CH_RED;
            started_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            seen_reg      <= '0;
            nonblack_reg  <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_reg      <= byte_next;
            chan_reg      <= chan_next;
            started_reg   <= started_next;
            res_valid_reg <= res_valid_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            seen_reg      <= seen_next;
            nonblack_reg  <= nonblack_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:          width_reg  <= width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg    <= pix_next;
        area_reg   <= area_next;
        fvalid_reg <= fvalid_next;
        mred_reg   <= mred_next;
        mgreen_reg <= mgreen_next;
        mblue_reg  <= mblue_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `FPS_ASSERT(a_no_early_result, (pix_valid && !pix_stall && !res_valid) |=> !res_valid, "result raised right after a pixel request")
    `FPS_ASSERT(a_invalid_zero, (res_valid && !res.frame_valid) |-> ((res.pixel_hash == '0) && (res.nonblack_count == '0) && (res.mean_red == '0) && (res.mean_green == '0) && (res.mean_blue == '0)), "invalid frame carries nonzero statistics")
    `FPS_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
    `FPS_ASSERT_ALWAYS(a_reset_no_result, !rst_n |-> !res_valid, "result valid during reset")

endmodule
